// File: design/swbs_pkg.sv
// ----------------------------------------------------------------------------
// swbs_pkg
// Shared widths, size limits, reset sizes, register indexes and the result
// type of the square window box sum block.
// ----------------------------------------------------------------------------
package swbs_pkg;

  localparam int MAX_GRID_DEF   = 1024;
  localparam int MAX_WINDOW_DEF = 64;

  localparam int SAMPLE_W      = 32;
  localparam int SUM_W         = 64;
  localparam int GRID_SIZE_W   = 11;
  localparam int WINDOW_SIZE_W = 7;
  localparam int CFG_DATA_W    = 11;

  localparam int GRID_SIZE_RST   = 4;
  localparam int WINDOW_SIZE_RST = 2;

  typedef enum logic [0:0] {
    CFG_GRID_SIZE   = 1'b0,
    CFG_WINDOW_SIZE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic                    is_total;
    logic                    last;
  } res_t;

endpackage

// File: design/swbs_cfg_if.sv
// ----------------------------------------------------------------------------
// swbs_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface swbs_cfg_if;
  logic                              valid;
  logic                              ready;
  swbs_pkg::cfg_idx_t                index;
  logic [swbs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/swbs_in_if.sv
// ----------------------------------------------------------------------------
// swbs_in_if
// Sample channel: valid, ready and one signed grid sample per item.
// ----------------------------------------------------------------------------
interface swbs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swbs_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// File: design/swbs_out_if.sv
// ----------------------------------------------------------------------------
// swbs_out_if
// Result channel: valid, ready, a 64-bit sum and its total and last flags.
// ----------------------------------------------------------------------------
interface swbs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [swbs_pkg::SUM_W-1:0] sum_value;
  logic                              is_total;
  logic                              last;

  modport source (output valid, sum_value, is_total, last, input ready);
  modport sink   (input valid, sum_value, is_total, last, output ready);
endinterface

// File: design/swbs_ram.sv
// ----------------------------------------------------------------------------
// swbs_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered (read-first on a shared address).
// ----------------------------------------------------------------------------
module swbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/square_window_box_sum.sv
// ----------------------------------------------------------------------------
// square_window_box_sum
// Sliding square-window sums over a square grid streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch writes grid_size (index 0) and window_size (index 1); it is always
//   ready and a write restarts the grid. Write only while the block is idle.
//   in_ch takes one signed sample per item in raster order. out_ch gives the
//   sum of each window when its bottom-right sample has arrived, in raster
//   order, and after the last sample of the grid a total of all window sums
//   with is_total and last set. A window larger than the grid gives only a
//   zero total.
// Timing:
//   One item per cycle while in_ch.ready is high. An item accepted on in_ch
//   passes through the read of the history and column-sum RAMs, column-sum
//   update, row-window update, then the grand-total adder feeding a
//   four-entry result queue. The column-sum RAM is kept twice so the current
//   column and the column leaving the window are read in the same cycle.
// Reset and stall:
//   Reset restores grid_size 4 and window_size 2 and starts a new grid; the
//   RAMs need no clearing. When the receiver stalls, in_ch.ready drops as soon
//   as more than two results wait in the queue, and the pipeline holds.
// ----------------------------------------------------------------------------
module square_window_box_sum #(
  parameter int MAX_GRID   = swbs_pkg::MAX_GRID_DEF,
  parameter int MAX_WINDOW = swbs_pkg::MAX_WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swbs_cfg_if.sink   cfg_ch,
  swbs_in_if.sink    in_ch,
  swbs_out_if.source out_ch
);

  localparam int SAMPLE_W = swbs_pkg::SAMPLE_W;
  localparam int SUM_W    = swbs_pkg::SUM_W;
  localparam int CW       = $clog2(MAX_GRID);
  localparam int WIW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW       = $clog2(MAX_WINDOW + 1);
  localparam int CMPW     = ((CW > WW) ? CW : WW) + 1;
  localparam int HAW      = WIW + CW;
  localparam int HDEPTH   = 1 << HAW;
  localparam int CSW      = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int RWW      = CSW + $clog2(MAX_WINDOW);
  localparam int QD       = 4;
  localparam int N_RST    = (swbs_pkg::GRID_SIZE_RST > MAX_GRID) ?
                            MAX_GRID : swbs_pkg::GRID_SIZE_RST;
  localparam int W_RST    = (swbs_pkg::WINDOW_SIZE_RST > MAX_WINDOW) ?
                            MAX_WINDOW : swbs_pkg::WINDOW_SIZE_RST;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                first_row;
    logic                hist_v;
    logic                c0;
    logic                sub_en;
    logic                emit_w;
    logic                emit_t;
    logic                fwd_a;
    logic                fwd_b;
    logic [HAW-1:0]      h_addr;
    logic [CW-1:0]       col;
  } s1_t;

  typedef struct packed {
    logic [CSW-1:0] cs_new;
    logic [CSW-1:0] cs_out;
    logic           c0;
    logic           emit_w;
    logic           emit_t;
  } s2_t;

  typedef struct packed {
    logic [RWW-1:0] ws;
    logic           emit_w;
    logic           emit_t;
  } s3_t;

  // Configuration and position state.
  logic [CW-1:0]  n_m1_r, n_m1_nxt;
  logic [WW-1:0]  w_r, w_nxt;
  logic [CW-1:0]  r_r, r_nxt;
  logic [CW-1:0]  c_r, c_nxt;
  logic [WIW-1:0] hr_r, hr_nxt;

  logic cfg_wr, acc, adv;
  logic [CMPW-1:0] rx, cx, wx, hx, cb_full;
  logic [CW-1:0]   cb;
  logic            last_c, last_r;

  // Pipeline.
  logic           s1_v_r, s2_v_r, s3_v_r;
  s1_t            s1_r, s1_nxt;
  s2_t            s2_r, s2_nxt;
  s3_t            s3_r, s3_nxt;
  logic [CSW-1:0] fwd_d_r;

  logic [SAMPLE_W-1:0] hist_rd;
  logic [CSW-1:0]      cs_rd_a, cs_rd_b;
  logic [CSW-1:0]      old_v, cs_prev;

  logic [RWW-1:0]   rws_r, rws_nxt, rws_new;
  logic [SUM_W-1:0] gt_r, gt_nxt, gt_new, wsum;

  // Result queue.
  swbs_pkg::res_t q_r [QD];
  swbs_pkg::res_t win_res, tot_res;
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push_w, push_t, pop;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  // The queue must have room for two results from the last stage before it advances.
  assign adv         = (cnt_r <= 3'(QD - 2));
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;

  assign rx      = CMPW'(r_r);
  assign cx      = CMPW'(c_r);
  assign wx      = CMPW'(w_r);
  assign hx      = CMPW'(hr_r);
  assign cb_full = cx - wx;
  assign cb      = cb_full[CW-1:0];
  assign last_c  = (c_r == n_m1_r);
  assign last_r  = (r_r == n_m1_r);

  // Register writes, with sizes clamped to the supported range.
  always_comb begin
    n_m1_nxt = n_m1_r;
    w_nxt    = w_r;
    if (cfg_wr) begin
      unique case (cfg_ch.index)
        swbs_pkg::CFG_GRID_SIZE: begin
          if (cfg_ch.data == '0) begin
            n_m1_nxt = '0;
          end else if (int'(cfg_ch.data) > MAX_GRID) begin
            n_m1_nxt = CW'(MAX_GRID - 1);
          end else begin
            n_m1_nxt = CW'(cfg_ch.data - 1'b1);
          end
        end
        swbs_pkg::CFG_WINDOW_SIZE: begin
          if (cfg_ch.data[swbs_pkg::WINDOW_SIZE_W-1:0] == '0) begin
            w_nxt = WW'(1);
          end else if (int'(cfg_ch.data[swbs_pkg::WINDOW_SIZE_W-1:0]) > MAX_WINDOW) begin
            w_nxt = WW'(MAX_WINDOW);
          end else begin
            w_nxt = WW'(cfg_ch.data[swbs_pkg::WINDOW_SIZE_W-1:0]);
          end
        end
        default: begin
          n_m1_nxt = n_m1_r;
        end
      endcase
    end
  end

  // Raster position; hr tracks the history row, which is row mod window.
  always_comb begin
    r_nxt  = r_r;
    c_nxt  = c_r;
    hr_nxt = hr_r;
    if (cfg_wr) begin
      r_nxt  = '0;
      c_nxt  = '0;
      hr_nxt = '0;
    end else if (acc) begin
      if (last_c) begin
        c_nxt = '0;
        if (last_r) begin
          r_nxt  = '0;
          hr_nxt = '0;
        end else begin
          r_nxt  = r_r + 1'b1;
          hr_nxt = (hx == wx - 1'b1) ? '0 : hr_r + 1'b1;
        end
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
  end

  // Stage 1 capture. A column sum being written this cycle is forwarded,
  // since the RAM read of the same address returns the old entry.
  always_comb begin
    s1_nxt.sample    = in_ch.sample;
    s1_nxt.first_row = (r_r == '0);
    s1_nxt.hist_v    = (rx >= wx);
    s1_nxt.c0        = (c_r == '0);
    s1_nxt.sub_en    = (cx >= wx);
    s1_nxt.emit_w    = (rx + 1'b1 >= wx) && (cx + 1'b1 >= wx);
    s1_nxt.emit_t    = last_c && last_r;
    s1_nxt.fwd_a     = s1_v_r && (s1_r.col == c_r);
    s1_nxt.fwd_b     = s1_v_r && (s1_r.col == cb);
    s1_nxt.h_addr    = {hr_r, c_r};
    s1_nxt.col       = c_r;
  end

  swbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(HDEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (adv && s1_v_r),
    .waddr (s1_r.h_addr),
    .wdata (s1_r.sample),
    .re    (acc),
    .raddr ({hr_r, c_r}),
    .rdata (hist_rd)
  );

  swbs_ram #(.WIDTH(CSW), .DEPTH(MAX_GRID)) u_cs_ram_a (
    .clk   (clk),
    .we    (adv && s1_v_r),
    .waddr (s1_r.col),
    .wdata (s2_nxt.cs_new),
    .re    (acc),
    .raddr (c_r),
    .rdata (cs_rd_a)
  );

  swbs_ram #(.WIDTH(CSW), .DEPTH(MAX_GRID)) u_cs_ram_b (
    .clk   (clk),
    .we    (adv && s1_v_r),
    .waddr (s1_r.col),
    .wdata (s2_nxt.cs_new),
    .re    (acc),
    .raddr (cb),
    .rdata (cs_rd_b)
  );

  // Stage 1: new column sum and the column sum leaving the window.
  always_comb begin
    old_v   = s1_r.hist_v ? CSW'($signed(hist_rd)) : '0;
    cs_prev = s1_r.first_row ? '0 : (s1_r.fwd_a ? fwd_d_r : cs_rd_a);
    s2_nxt.cs_new = cs_prev - old_v + CSW'($signed(s1_r.sample));
    s2_nxt.cs_out = s1_r.sub_en ? (s1_r.fwd_b ? fwd_d_r : cs_rd_b) : '0;
    s2_nxt.c0     = s1_r.c0;
    s2_nxt.emit_w = s1_r.emit_w;
    s2_nxt.emit_t = s1_r.emit_t;
  end

  // Stage 2: running sum of the last window_size column sums in this row.
  always_comb begin
    rws_new = (s2_r.c0 ? '0 : rws_r) + RWW'($signed(s2_r.cs_new))
              - RWW'($signed(s2_r.cs_out));
    rws_nxt = rws_r;
    if (cfg_wr) begin
      rws_nxt = '0;
    end else if (adv && s2_v_r) begin
      rws_nxt = rws_new;
    end
    s3_nxt.ws     = rws_new;
    s3_nxt.emit_w = s2_r.emit_w;
    s3_nxt.emit_t = s2_r.emit_t;
  end

  // Stage 3: grand total and results into the queue.
  always_comb begin
    wsum   = SUM_W'($signed(s3_r.ws));
    gt_new = gt_r + (s3_r.emit_w ? wsum : '0);
    gt_nxt = gt_r;
    if (cfg_wr) begin
      gt_nxt = '0;
    end else if (adv && s3_v_r) begin
      gt_nxt = s3_r.emit_t ? '0 : gt_new;
    end
    win_res.sum_value = wsum;
    win_res.is_total  = 1'b0;
    win_res.last      = 1'b0;
    tot_res.sum_value = gt_new;
    tot_res.is_total  = 1'b1;
    tot_res.last      = 1'b1;
  end

  assign push_w = adv && s3_v_r && s3_r.emit_w;
  assign push_t = adv && s3_v_r && s3_r.emit_t;
  assign pop    = out_ch.valid && out_ch.ready;

  always_comb begin
    wp_nxt  = wp_r + 2'(push_w) + 2'(push_t);
    rp_nxt  = rp_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(push_w) + 3'(push_t) - 3'(pop);
  end

  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.sum_value = q_r[rp_r].sum_value;
  assign out_ch.is_total  = q_r[rp_r].is_total;
  assign out_ch.last      = q_r[rp_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_m1_r <= CW'(N_RST - 1);
      w_r    <= WW'(W_RST);
      r_r    <= '0;
      c_r    <= '0;
      hr_r   <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      rws_r  <= '0;
      gt_r   <= '0;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else begin
      n_m1_r <= n_m1_nxt;
      w_r    <= w_nxt;
      r_r    <= r_nxt;
      c_r    <= c_nxt;
      hr_r   <= hr_nxt;
      rws_r  <= rws_nxt;
      gt_r   <= gt_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
      if (adv) begin
        s1_v_r <= acc;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r    <= s1_nxt;
      fwd_d_r <= s2_nxt.cs_new;
    end
    if (adv) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
    if (push_w) begin
      q_r[wp_r] <= win_res;
    end
    if (push_t) begin
      q_r[wp_r + 2'(push_w)] <= tot_res;
    end
  end

endmodule
